// File: design/matrix_vector_product_core_macros.svh
// Assertion macros for the matrix-vector product core checker.
// Included by the checker file only; no other dependencies.
`ifndef MATRIX_VECTOR_PRODUCT_CORE_MACROS_SVH
`define MATRIX_VECTOR_PRODUCT_CORE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define MVP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define MVP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mvp_pkg.sv
// Shared types and constants for the matrix-vector product core.
// No dependencies; used by every module of the block.
`default_nettype none

package mvp_pkg;

    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int ROW_W = 16;
    localparam int COLS_REG_W = 11;

    // Input word kinds
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROW_W-1:0]      ROWS_RESET = 16'd1024;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // Result queue
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PW    = 2;
    localparam int OFIFO_CW    = 3;

    typedef struct packed {
        logic             first;
        logic             row_end;
        logic             last;
        logic [ROW_W-1:0] row_index;
    } t_ctrl;

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0] row_index;
        logic             last;
        logic             sat;
    } t_result;

endpackage

`default_nettype wire

// File: design/mvp_vstore.sv
// Vector store: single-port-write, single-port-read RAM with a registered read port.
// Depends on mvp_pkg for the element width.
`default_nettype none

module mvp_vstore #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [AW-1:0]              i_waddr,
    input  wire [mvp_pkg::VAL_W-1:0]  i_wdata,
    input  wire                       i_re,
    input  wire [AW-1:0]              i_raddr,
    output logic [mvp_pkg::VAL_W-1:0] o_rdata
);

    logic [mvp_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [mvp_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/mvp_mac.sv
// Multiply stage and saturating Q32.32 accumulator.
// Depends on mvp_pkg for t_ctrl, t_result and the saturation limits.
`default_nettype none

module mvp_mac (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    input  wire [mvp_pkg::VAL_W-1:0]  i_elem,
    input  wire [mvp_pkg::VAL_W-1:0]  i_vec,
    input  mvp_pkg::t_ctrl            i_ctrl,
    output logic                      o_push,
    output mvp_pkg::t_result          o_result,
    output logic                      o_pend
);

    logic                             r_v2;
    logic signed [mvp_pkg::SUM_W-1:0] r_prod;
    mvp_pkg::t_ctrl                   r_ctrl2;
    logic signed [mvp_pkg::SUM_W-1:0] r_acc;
    logic                             r_sat;

    logic signed [mvp_pkg::SUM_W-1:0] w_prod;
    logic signed [mvp_pkg::SUM_W-1:0] w_a;
    logic signed [mvp_pkg::SUM_W-1:0] w_s;
    logic signed [mvp_pkg::SUM_W-1:0] w_sum;
    logic                             w_ovf;
    logic                             w_sat;
    logic signed [mvp_pkg::SUM_W-1:0] n_acc;
    logic                             n_sat;

    // 32x32 signed product; the operands are sign-extended to the product width
    assign w_prod = mvp_pkg::SUM_W'($signed(i_elem)) * mvp_pkg::SUM_W'($signed(i_vec));

    always_comb begin
        w_a   = r_ctrl2.first ? '0 : r_acc;
        w_s   = w_a + r_prod;
        w_ovf = (w_a[mvp_pkg::SUM_W-1] == r_prod[mvp_pkg::SUM_W-1]) &&
                (w_s[mvp_pkg::SUM_W-1] != w_a[mvp_pkg::SUM_W-1]);
        if (w_ovf) begin
            w_sum = w_a[mvp_pkg::SUM_W-1] ? mvp_pkg::SUM_MIN : mvp_pkg::SUM_MAX;
        end else begin
            w_sum = w_s;
        end
        w_sat = (r_ctrl2.first ? 1'b0 : r_sat) | w_ovf;
        // clear at row end so a shortened row still starts from zero
        n_acc = r_ctrl2.row_end ? '0 : w_sum;
        n_sat = r_ctrl2.row_end ? 1'b0 : w_sat;
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_ctrl2 <= i_ctrl;
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_acc <= '0;
            r_sat <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            if (r_v2) begin
                r_acc <= n_acc;
                r_sat <= n_sat;
            end
        end
    end

    assign o_push             = r_v2 & r_ctrl2.row_end;
    assign o_pend             = o_push;
    assign o_result.row_sum   = w_sum;
    assign o_result.row_index = r_ctrl2.row_index;
    assign o_result.last      = r_ctrl2.last;
    assign o_result.sat       = w_sat;

endmodule

`default_nettype wire

// File: design/mvp_ofifo.sv
// Result queue between the accumulator and the output stream.
// Depends on mvp_pkg for t_result and the queue sizes.
`default_nettype none

module mvp_ofifo (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  mvp_pkg::t_result             i_data,
    input  wire                          i_pop,
    output logic                         o_valid,
    output mvp_pkg::t_result             o_data,
    output logic [mvp_pkg::OFIFO_CW-1:0] o_count
);

    mvp_pkg::t_result              r_mem [mvp_pkg::OFIFO_DEPTH];
    logic [mvp_pkg::OFIFO_PW-1:0]  r_wp;
    logic [mvp_pkg::OFIFO_PW-1:0]  r_rp;
    logic [mvp_pkg::OFIFO_CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + mvp_pkg::OFIFO_PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + mvp_pkg::OFIFO_PW'(1);
            end
            r_cnt <= r_cnt + mvp_pkg::OFIFO_CW'(i_push) - mvp_pkg::OFIFO_CW'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: design/matrix_vector_product_core.sv
// Dense matrix-vector product on a word stream. Words with tuser = 0 load the
// vector, one element per word, into an on-chip RAM; words with tuser = 1 are
// matrix elements in row-major order. One word is taken every cycle while ready is
// high, loads and matrix elements alike; the rate is set by the single 32x32
// multiplier and the 64-bit saturating accumulator, each with its own register
// stage. A row result passes the input register and the product register into a
// four-word queue; input ready drops only when that queue has no room for the
// results still in flight. Register 0 (paddr 0) sets the column count, register
// 1 (paddr 4) the row count; write them only while the block is idle.
// Depends on mvp_pkg, mvp_vstore, mvp_mac and mvp_ofifo.
`default_nettype none

module matrix_vector_product_core #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 65535
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire  [0:0]  i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [63:0] row_sum, [79:64] row_index
    output logic        o_m_axis_tlast,   // last_row
    output logic [0:0]  o_m_axis_tuser,   // [0] saturated
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1) + 1;
    localparam int RW    = mvp_pkg::ROW_W + 1;

    logic [mvp_pkg::COLS_REG_W-1:0] r_cols;
    logic [mvp_pkg::ROW_W-1:0]      r_rows;
    logic [AW-1:0]                  r_load_ptr;
    logic [AW-1:0]                  r_col;
    logic [mvp_pkg::ROW_W-1:0]      r_row;
    logic                           r_v1;
    logic [mvp_pkg::VAL_W-1:0]      r_elem1;
    mvp_pkg::t_ctrl                 r_ctrl1;

    logic [CNT_W-1:0]          w_cols;
    logic [CNT_W-1:0]          w_cols_m1;
    logic [RW-1:0]             w_rows;
    logic [RW-1:0]             w_rows_m1;
    logic [AW-1:0]             w_lp;
    logic [CNT_W-1:0]          w_lp_inc;
    logic [AW-1:0]             n_load_ptr;
    logic [AW-1:0]             w_col;
    logic [CNT_W-1:0]          w_col_inc;
    logic                      w_row_end;
    logic [mvp_pkg::ROW_W-1:0] w_row;
    logic                      w_last;
    logic                      w_acc;
    logic                      w_is_mat;
    logic                      w_cfg_wr;
    mvp_pkg::t_ctrl            w_ctrl;

    logic [mvp_pkg::VAL_W-1:0]     w_vec;
    logic                          w_push;
    mvp_pkg::t_result              w_res;
    logic                          w_pend2;
    logic                          w_ovalid;
    mvp_pkg::t_result              w_odata;
    logic [mvp_pkg::OFIFO_CW-1:0]  w_ocount;
    logic [mvp_pkg::OFIFO_CW-1:0]  w_need;

    // Effective sizes: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_cols == '0) begin
            w_cols = CNT_W'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            w_cols = CNT_W'(MAX_COLS);
        end else begin
            w_cols = CNT_W'(r_cols);
        end
        w_cols_m1 = w_cols - CNT_W'(1);

        if (r_rows == '0) begin
            w_rows = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_rows = RW'(MAX_ROWS);
        end else begin
            w_rows = RW'(r_rows);
        end
        w_rows_m1 = w_rows - RW'(1);
    end

    // Load pointer, column and row positions of the word on the input
    always_comb begin
        w_lp       = (CNT_W'(r_load_ptr) >= w_cols) ? '0 : r_load_ptr;
        w_lp_inc   = CNT_W'(w_lp) + CNT_W'(1);
        n_load_ptr = (w_lp_inc >= w_cols) ? '0 : w_lp_inc[AW-1:0];

        w_col      = (CNT_W'(r_col) >= w_cols) ? w_cols_m1[AW-1:0] : r_col;
        w_col_inc  = CNT_W'(w_col) + CNT_W'(1);
        w_row_end  = (w_col_inc >= w_cols);

        w_row  = ({1'b0, r_row} >= w_rows) ? w_rows_m1[mvp_pkg::ROW_W-1:0] : r_row;
        w_last = (({1'b0, w_row} + RW'(1)) >= w_rows);

        w_ctrl.first     = (w_col == '0);
        w_ctrl.row_end   = w_row_end;
        w_ctrl.last      = w_last;
        w_ctrl.row_index = w_row;
    end

    assign w_acc    = i_s_axis_tvalid & o_s_axis_tready;
    assign w_is_mat = (i_s_axis_tuser[0] == mvp_pkg::CMD_MATRIX);
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        r_elem1 <= i_s_axis_tdata;
        r_ctrl1 <= w_ctrl;
        if (!i_rst_n) begin
            r_cols     <= mvp_pkg::COLS_RESET;
            r_rows     <= mvp_pkg::ROWS_RESET;
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_v1       <= 1'b0;
        end else begin
            r_v1 <= w_acc & w_is_mat;
            if (w_cfg_wr) begin
                if (paddr[2] == mvp_pkg::REG_ROWS) begin
                    r_rows <= pwdata[mvp_pkg::ROW_W-1:0];
                end else begin
                    r_cols <= pwdata[mvp_pkg::COLS_REG_W-1:0];
                end
            end
            if (w_acc && !w_is_mat) begin
                r_load_ptr <= n_load_ptr;
            end
            if (w_acc && w_is_mat) begin
                r_col <= w_row_end ? '0 : w_col_inc[AW-1:0];
                if (w_row_end) begin
                    r_row <= w_last ? '0 : (w_row + mvp_pkg::ROW_W'(1));
                end
            end
        end
    end

    mvp_vstore #(
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_acc & ~w_is_mat),
        .i_waddr (w_lp),
        .i_wdata (i_s_axis_tdata),
        .i_re    (w_acc & w_is_mat),
        .i_raddr (w_col),
        .o_rdata (w_vec)
    );

    mvp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_elem   (r_elem1),
        .i_vec    (w_vec),
        .i_ctrl   (r_ctrl1),
        .o_push   (w_push),
        .o_result (w_res),
        .o_pend   (w_pend2)
    );

    mvp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_pop   (w_ovalid & i_m_axis_tready),
        .o_valid (w_ovalid),
        .o_data  (w_odata),
        .o_count (w_ocount)
    );

    // Reserve queue room for every row result still in the pipeline
    assign w_need = w_ocount + mvp_pkg::OFIFO_CW'(r_v1 & r_ctrl1.row_end)
                  + mvp_pkg::OFIFO_CW'(w_pend2);
    assign o_s_axis_tready = (w_need < mvp_pkg::OFIFO_CW'(mvp_pkg::OFIFO_DEPTH));

    assign o_m_axis_tvalid = w_ovalid;
    assign o_m_axis_tdata  = {w_odata.row_index, w_odata.row_sum};
    assign o_m_axis_tlast  = w_odata.last;
    assign o_m_axis_tuser  = w_odata.sat;

    assign prdata = (paddr[2] == mvp_pkg::REG_ROWS) ? 32'(r_rows) : 32'(r_cols);
    assign pready = 1'b1;

endmodule

`default_nettype wire

// File: design/mvp_checker.sv
// Port-level checks for the matrix-vector product core, bound to the top level.
// Depends on matrix_vector_product_core_macros.svh.
`default_nettype none
`include "matrix_vector_product_core_macros.svh"

module mvp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [0:0]  i_s_axis_tuser,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [79:0] o_m_axis_tdata
);

    // A stalled result word holds its data
    `MVP_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result word changed while stalled")

    // A result word rising on an empty queue traces back to a taken matrix word
    `MVP_ASSERT(a_out_latency, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0], 3), "result without a matching matrix word")

    // Reset drops the result queue
    `MVP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind matrix_vector_product_core mvp_checker u_mvp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// File: bench/matrix_vector_product_core_tb.sv
// Self-checking bench for matrix_vector_product_core: directed words, then random phases.
// Row results are predicted in the bench and compared field by field as they leave.
// Depends on mvp_pkg and the core itself.
`timescale 1ns / 100ps

module matrix_vector_product_core_tb;

    localparam int HALF_PERIOD    = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_WORDS = 22;
    localparam int STORE_DEPTH    = 1024;
    localparam int ROWS_LIMIT     = 65535;

    typedef struct packed {
        logic    kind;
        logic    [31:0] value;
        logic    typed;
        mvp_pkg::t_result want;
    } t_directed_word;

    localparam mvp_pkg::t_result NO_ROW = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        word_valid = 1'b0;
    logic [31:0] word_data = '0;
    logic [0:0]  word_kind = '0;
    logic        row_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [79:0] o_m_axis_tdata;
    wire         o_m_axis_tlast;
    wire  [0:0]  o_m_axis_tuser;
    wire  [31:0] prdata;
    wire         pready;

    // Bench copy of the block state
    logic [31:0] vec_copy [STORE_DEPTH];
    logic [9:0]  load_idx = '0;
    logic [9:0]  col_idx = '0;
    logic [15:0] row_idx = '0;
    logic [63:0] row_acc = '0;
    logic        row_clamped = 1'b0;
    logic [10:0] cols_setting = mvp_pkg::COLS_RESET;
    logic [15:0] rows_setting = mvp_pkg::ROWS_RESET;

    mvp_pkg::t_result pending_rows [$];
    mvp_pkg::t_result seen_row;
    mvp_pkg::t_result popped_row;
    int          errors = 0;
    int          words_taken = 0;
    int          rows_checked = 0;
    int          rows_saturated = 0;
    int          settings_used = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    t_directed_word directed_words [DIRECTED_WORDS] = '{
        '{mvp_pkg::CMD_LOAD,   32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_LOAD,   32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_LOAD,   32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_LOAD,   32'h8000_0000, 1'b0, NO_ROW},
        // most negative squared: clamps high on the second column and stays there
        '{mvp_pkg::CMD_MATRIX, 32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h8000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h8000_0000, 1'b1, '{mvp_pkg::SUM_MAX, 16'd0, 1'b0, 1'b1}},
        // opposite signs: clamps low on the third column
        '{mvp_pkg::CMD_MATRIX, 32'h7FFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h7FFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h7FFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h7FFF_FFFF, 1'b1, '{mvp_pkg::SUM_MIN, 16'd1, 1'b0, 1'b1}},
        '{mvp_pkg::CMD_MATRIX, 32'h0000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h0000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h0000_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h0000_0000, 1'b1, '{64'd0, 16'd2, 1'b1, 1'b0}},
        // reload part of the vector in the middle of a row
        '{mvp_pkg::CMD_MATRIX, 32'h0001_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_LOAD,   32'h7FFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_LOAD,   32'hFFFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'hFFFF_FFFF, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h0001_0000, 1'b0, NO_ROW},
        '{mvp_pkg::CMD_MATRIX, 32'h1234_5678, 1'b0, NO_ROW}
    };

    matrix_vector_product_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (word_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (word_data),   // [31:0] value
        .i_s_axis_tuser  (word_kind),   // [0] command
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (row_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [63:0] row_sum, [79:64] row_index
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] saturated
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned active_cols();
        if (cols_setting == 0) return 1;
        if (cols_setting > STORE_DEPTH) return STORE_DEPTH;
        return cols_setting;
    endfunction

    function automatic int unsigned active_rows();
        if (rows_setting == 0) return 1;
        if (rows_setting > ROWS_LIMIT) return ROWS_LIMIT;
        return rows_setting;
    endfunction

    // Advance the bench state by one word; a finished row yields its result
    task automatic compute_row_result(input logic kind, input logic [31:0] value,
                                      output bit has_row, output mvp_pkg::t_result row);
        int unsigned cols;
        int unsigned rows;
        int unsigned col;
        int unsigned ptr;
        int unsigned r;
        longint      prod;
        logic [63:0] sum;
        cols = active_cols();
        rows = active_rows();
        has_row = 1'b0;
        row = '0;
        if (kind == mvp_pkg::CMD_LOAD) begin
            ptr = load_idx;
            if (ptr >= cols) ptr = 0;
            vec_copy[ptr] = value;
            ptr++;
            load_idx = (ptr >= cols) ? 10'd0 : ptr[9:0];
            return;
        end
        col = col_idx;
        if (col >= cols) col = cols - 1;
        if (col == 0) begin
            row_acc = '0;
            row_clamped = 1'b0;
        end
        prod = longint'($signed(value)) * longint'($signed(vec_copy[col]));
        sum = row_acc + prod;
        if (row_acc[63] == prod[63] && sum[63] != row_acc[63]) begin
            sum = row_acc[63] ? mvp_pkg::SUM_MIN : mvp_pkg::SUM_MAX;
            row_clamped = 1'b1;
        end
        row_acc = sum;
        if (col + 1 < cols) begin
            col_idx = 10'(col + 1);
            return;
        end
        col_idx = '0;
        r = row_idx;
        if (r >= rows) r = rows - 1;
        row.row_sum = row_acc;
        row.row_index = r[15:0];
        row.last = (r + 1 >= rows);
        row.sat = row_clamped;
        has_row = 1'b1;
        row_idx = row.last ? 16'd0 : 16'(r + 1);
        row_acc = '0;
        row_clamped = 1'b0;
    endtask

    // Offer one word, wait for it to be taken, then log what it should produce
    task automatic send_word(input logic kind, input logic [31:0] value,
                             input bit typed, input mvp_pkg::t_result typed_row);
        bit               has_row;
        mvp_pkg::t_result row;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        word_valid <= 1'b1;
        word_data <= value;
        word_kind <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        words_taken++;
        compute_row_result(kind, value, has_row, row);
        if (has_row) pending_rows.push_back(typed ? typed_row : row);
    endtask

    task automatic write_reg(input logic which, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (which == mvp_pkg::REG_COLS) cols_setting = data[mvp_pkg::COLS_REG_W-1:0];
        else rows_setting = data[mvp_pkg::ROW_W-1:0];
    endtask

    task automatic read_reg(input logic which, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {which, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        unique case ($urandom_range(0, 7))
            0: return extremes[$urandom_range(0, 3)];
            1: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    // One register setting: fill the vector, stream random words, optionally park mid-row
    task automatic run_phase(input logic [10:0] cols_val, input logic [15:0] rows_val,
                             input int n_words, input bit idle, input bit pressure,
                             input int park_col);
        logic [31:0] junk;
        int unsigned fill;
        wait_drained();
        idle_on = idle && !pressure;
        junk = $urandom;
        write_reg(mvp_pkg::REG_COLS, {junk[31:11], cols_val});
        junk = $urandom;
        write_reg(mvp_pkg::REG_ROWS, {junk[31:16], rows_val});
        settings_used++;
        fill = active_cols();
        repeat (fill) send_word(mvp_pkg::CMD_LOAD, pick_value(), 1'b0, NO_ROW);
        if (pressure) hold_req = 1'b1;
        repeat (n_words) begin
            if ($urandom_range(0, 99) < 12)
                send_word(mvp_pkg::CMD_LOAD, pick_value(), 1'b0, NO_ROW);
            else
                send_word(mvp_pkg::CMD_MATRIX, pick_value(), 1'b0, NO_ROW);
        end
        // leave the column position part-way through a row for the next setting
        if (park_col >= 0)
            while (col_idx != park_col)
                send_word(mvp_pkg::CMD_MATRIX, pick_value(), 1'b0, NO_ROW);
        word_valid <= 1'b0;
    endtask

    // Oversized column count: load and stream part of a long row, then park there
    task automatic run_oversize(input int n_loads, input int n_mats);
        wait_drained();
        idle_on = 1'b1;
        write_reg(mvp_pkg::REG_COLS, 32'h0000_07FF);
        write_reg(mvp_pkg::REG_ROWS, 32'd1);
        settings_used++;
        repeat (n_loads) send_word(mvp_pkg::CMD_LOAD, pick_value(), 1'b0, NO_ROW);
        repeat (n_mats) send_word(mvp_pkg::CMD_MATRIX, pick_value(), 1'b0, NO_ROW);
        word_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                row_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                row_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                row_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && row_ready) begin
            seen_row.row_sum = o_m_axis_tdata[63:0];
            seen_row.row_index = o_m_axis_tdata[79:64];
            seen_row.last = o_m_axis_tlast;
            seen_row.sat = o_m_axis_tuser[0];
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row result, expected none, got sum %h row %0d",
                         $time, seen_row.row_sum, seen_row.row_index);
                errors++;
            end else begin
                popped_row = pending_rows.pop_front();
                rows_checked++;
                if (seen_row.sat) rows_saturated++;
                if (seen_row.row_sum !== popped_row.row_sum) begin
                    $display("%0t: row_sum expected %h got %h", $time,
                             popped_row.row_sum, seen_row.row_sum);
                    errors++;
                end
                if (seen_row.row_index !== popped_row.row_index) begin
                    $display("%0t: row_index expected %0d got %0d", $time,
                             popped_row.row_index, seen_row.row_index);
                    errors++;
                end
                if (seen_row.last !== popped_row.last) begin
                    $display("%0t: last_row expected %b got %b", $time,
                             popped_row.last, seen_row.last);
                    errors++;
                end
                if (seen_row.sat !== popped_row.sat) begin
                    $display("%0t: saturated expected %b got %b", $time,
                             popped_row.sat, seen_row.sat);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (word_valid && o_s_axis_tready) || (o_m_axis_tvalid && row_ready)
            || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no traffic for %0d cycles, %0d rows still awaited", $time,
                         quiet_cycles, pending_rows.size());
                $display("FAIL matrix_vector_product_core");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] readback;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_reg(mvp_pkg::REG_COLS, readback);
        if (readback[mvp_pkg::COLS_REG_W-1:0] !== mvp_pkg::COLS_RESET) begin
            $display("%0t: cols_in_use after reset expected %0d got %0d", $time,
                     mvp_pkg::COLS_RESET, readback[mvp_pkg::COLS_REG_W-1:0]);
            errors++;
        end
        read_reg(mvp_pkg::REG_ROWS, readback);
        if (readback[mvp_pkg::ROW_W-1:0] !== mvp_pkg::ROWS_RESET) begin
            $display("%0t: rows_in_use after reset expected %0d got %0d", $time,
                     mvp_pkg::ROWS_RESET, readback[mvp_pkg::ROW_W-1:0]);
            errors++;
        end

        write_reg(mvp_pkg::REG_COLS, 32'd4);
        write_reg(mvp_pkg::REG_ROWS, 32'd3);
        settings_used++;
        for (int i = 0; i < DIRECTED_WORDS; i++)
            send_word(directed_words[i].kind, directed_words[i].value,
                      directed_words[i].typed, directed_words[i].want);
        word_valid <= 1'b0;

        run_phase(11'd3, 16'd5, 80, 1'b1, 1'b0, -1);
        run_phase(11'd0, 16'd0, 60, 1'b1, 1'b1, -1);
        run_phase(11'd2, 16'd65535, 70, 1'b1, 1'b0, -1);
        run_oversize(40, 30);
        run_phase(11'd7, 16'd2, 60, 1'b1, 1'b0, 6);
        run_phase(11'd5, 16'd0, 50, 1'b1, 1'b0, -1);
        run_phase(11'd16, 16'd4, 80, 1'b1, 1'b0, -1);
        repeat (2) run_phase(11'($urandom_range(1, 12)), 16'($urandom_range(0, 9)), 60,
                             1'b1, 1'b0, -1);
        run_phase(11'd1, 16'd3, 60, 1'b0, 1'b0, -1);
        wait_drained();

        $display("Run covered %0d words over %0d register settings.", words_taken,
                 settings_used);
        $display("%0d row results checked, %0d of them clamped; %0d mismatches.",
                 rows_checked, rows_saturated, errors);
        if (errors == 0) begin
            $display("PASS matrix_vector_product_core");
        end else begin
            $display("FAIL matrix_vector_product_core");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/mvp_pkg.sv
design/mvp_vstore.sv
design/mvp_mac.sv
design/mvp_ofifo.sv
design/matrix_vector_product_core.sv
design/mvp_checker.sv
bench/matrix_vector_product_core_tb.sv
